// ----- rtl/sprite_cell_clip_and_queue_core_macros.svh -----
// Assertion macros for the sprite cell clip and queue core.
// Included by the top level; expects clock and reset in scope.
`ifndef SPRITE_CELL_CLIP_AND_QUEUE_CORE_MACROS_SVH
`define SPRITE_CELL_CLIP_AND_QUEUE_CORE_MACROS_SVH

// Consequent checked in the same cycle.
`define SCQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the next cycle.
`define SCQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/scq_pkg.sv -----
// Shared types and constants for the sprite cell clip and queue core.
// No dependencies.
package scq_pkg;

   localparam int POS_W       = 16;
   localparam int ATTR_W      = 16;
   localparam int PRIO_W      = 2;
   localparam int SLOT_W      = 7;
   localparam int SCREEN_W    = 9;
   localparam int DEPTH_W     = 7;
   localparam int CSR_ADDR_W  = 1;
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 56;

   localparam int QUEUE_DEPTH_DEFAULT = 128;

   localparam logic signed [POS_W-1:0] X_LIMIT    = 16'sd256;
   localparam logic signed [POS_W-1:0] Y_LIMIT    = 16'sd224;
   localparam logic signed [POS_W-1:0] SMALL_LOW  = -16'sd16;
   localparam logic signed [POS_W-1:0] LARGE_LOW  = -16'sd32;
   localparam logic [POS_W-1:0]        DEPTH_BIAS = 16'd16;
   localparam logic [DEPTH_W-1:0]      DEPTH_MAX  = 7'd127;
   localparam logic [ATTR_W-1:0]       ATTR_KEEP  = 16'hcfff;
   localparam int                      PRIO_LSB   = 12;

   typedef enum logic [0:0] {
      OP_CELL  = 1'b0,
      OP_CLEAR = 1'b1
   } opcode_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_SCROLL_X = 1'b0,
      REG_SCROLL_Y = 1'b1
   } csr_reg_type;

   // Input transaction payload, first field in the highest bits.
   typedef struct packed {
      logic [PRIO_W-1:0]       priority_req;
      logic [ATTR_W-1:0]       cell_attr;
      logic                    cell_large;
      logic signed [POS_W-1:0] cell_offset_y;
      logic signed [POS_W-1:0] cell_offset_x;
      logic signed [POS_W-1:0] object_z;
      logic signed [POS_W-1:0] object_y;
      logic signed [POS_W-1:0] object_x;
   } req_item_type;

   // Result transaction payload, first field in the highest bits.
   typedef struct packed {
      logic [DEPTH_W-1:0]         depth;
      logic [ATTR_W-1:0]          tile_attr;
      logic                       size_large;
      logic                       x_negative;
      logic signed [SCREEN_W-1:0] screen_y;
      logic signed [SCREEN_W-1:0] screen_x;
      logic [SLOT_W-1:0]          slot;
   } rsp_item_type;

   // Geometry result handed from the calculator to the top level.
   typedef struct packed {
      logic         visible;
      rsp_item_type item;
   } calc_result_type;

endpackage

// ----- rtl/sprite_cell_clip_and_queue_core.sv -----
// Path: a req_ transaction accepted into the input register passes the combinational
//   compute stage, a few 16-bit adds and compares, into the result register, which
//   drives rsp_tvalid; clear, culled and full-queue cells produce no rsp_ transaction.
// Throughput: one req_ transaction per cycle unless a result waits for room in the
//   result register.
// Reset: synchronous, active high; clears pipeline valids, queue count and both
//   scroll registers. Payload registers are not reset.
`include "sprite_cell_clip_and_queue_core_macros.svh"

module sprite_cell_clip_and_queue_core #(
   parameter int QUEUE_DEPTH = scq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration write port
   input  logic                              csr_we,
   input  logic [scq_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [scq_pkg::POS_W-1:0]         csr_wdata,
   // Request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // object_x, object_y, object_z, cell_offset_x, cell_offset_y, cell_large,
   // cell_attr, priority_req (lowest bit up), zero pad
   input  logic [scq_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // opcode
   input  logic                              req_tuser,
   // Response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // slot, screen_x, screen_y, x_negative, size_large, tile_attr, depth
   // (lowest bit up), zero pad
   output logic [scq_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import scq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration registers
   logic signed [POS_W-1:0] scroll_x_ff, scroll_x_in;
   logic signed [POS_W-1:0] scroll_y_ff, scroll_y_in;

   // Input stage
   logic         s1_valid_ff, s1_valid_in;
   opcode_type   s1_op_ff, s1_op_in;
   req_item_type s1_item_ff, s1_item_in;

   // Queue count
   logic [CNT_W-1:0] count_ff, count_in;

   calc_result_type calc;
   rsp_item_type    load_item;
   rsp_item_type    rsp_item;
   logic            not_full;
   logic            hit;
   logic            s1_move;
   logic            load;
   logic            out_free;

   scq_calc u_calc (
      .item     (s1_item_ff),
      .scroll_x (scroll_x_ff),
      .scroll_y (scroll_y_ff),
      .result   (calc)
   );

   scq_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_item  (load_item),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_item   (rsp_item),
      .free       (out_free)
   );

   // CSR writes; user must write only when idle so compute stays stable; unchecked.
   always_comb begin
      scroll_x_in = scroll_x_ff;
      scroll_y_in = scroll_y_ff;
      if (csr_we) begin
         case (csr_reg_type'(csr_addr))
            REG_SCROLL_X: scroll_x_in = csr_wdata;
            REG_SCROLL_Y: scroll_y_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage control: a transaction with no result leaves the input stage at once;
   // one with a result waits for room in the result register.
   always_comb begin
      not_full  = count_ff < CNT_W'(QUEUE_DEPTH);
      hit       = (s1_op_ff == OP_CELL) && not_full && calc.visible;
      s1_move   = s1_valid_ff && (!hit || out_free);
      load      = s1_move && hit;
      req_tready = !s1_valid_ff || s1_move;

      s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;
      s1_op_in    = req_tready ? opcode_type'(req_tuser) : s1_op_ff;
      s1_item_in  = req_tready ? req_item_type'(req_tdata[$bits(req_item_type)-1:0])
                               : s1_item_ff;

      count_in = count_ff;
      if (s1_move && (s1_op_ff == OP_CLEAR)) begin
         count_in = '0;
      end else if (load) begin
         count_in = count_ff + CNT_W'(1);
      end

      load_item      = calc.item;
      load_item.slot = SLOT_W'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_x_ff <= '0;
         scroll_y_ff <= '0;
         s1_valid_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         scroll_x_ff <= scroll_x_in;
         scroll_y_ff <= scroll_y_in;
         s1_valid_ff <= s1_valid_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff   <= s1_op_in;
      s1_item_ff <= s1_item_in;
   end

   assign rsp_tdata = RSP_TDATA_W'(rsp_item);

   // Every queued sprite advances the count by exactly one.
   `SCQ_ASSERT_NEXT(a_count_step, load, count_ff == $past(count_ff) + CNT_W'(1), "count step")
   // A clear transaction empties the queue count.
   `SCQ_ASSERT_NEXT(a_clear, s1_move && (s1_op_ff == OP_CLEAR), count_ff == '0, "clear")
   // A loaded result carries the slot of the count it consumed.
   `SCQ_ASSERT_NEXT(a_slot, load, rsp_item.slot == SLOT_W'($past(count_ff)), "slot mismatch")
   // The queue count never passes its depth.
   `SCQ_ASSERT_NOW(a_bound, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "count overflow")

endmodule

// ----- rtl/scq_calc.sv -----
// Combinational cell geometry: screen position, window cull, depth, attribute.
// Depends on scq_pkg. Slot field is left zero; the top level fills it.
module scq_calc (
   input  scq_pkg::req_item_type           item,
   input  logic signed [scq_pkg::POS_W-1:0] scroll_x,
   input  logic signed [scq_pkg::POS_W-1:0] scroll_y,
   output scq_pkg::calc_result_type        result
);
   import scq_pkg::*;

   logic signed [POS_W-1:0] sx;
   logic signed [POS_W-1:0] sy;
   logic signed [POS_W-1:0] low;
   logic [POS_W-1:0]        raw;
   logic                    raw_pos;
   logic [DEPTH_W-1:0]      depth;

   always_comb begin
      sx  = item.object_x + item.cell_offset_x - scroll_x;
      sy  = item.object_y + item.cell_offset_y - item.object_z - scroll_y;
      low = item.cell_large ? LARGE_LOW : SMALL_LOW;

      // depth = clamp((oy + 16 - scroll_y) >> 1, 0, 127)
      raw     = item.object_y + DEPTH_BIAS - scroll_y;
      raw_pos = !raw[POS_W-1] && (raw != '0);
      if (!raw_pos) begin
         depth = '0;
      end else if (|raw[POS_W-2:DEPTH_W+1]) begin
         depth = DEPTH_MAX;
      end else begin
         depth = raw[DEPTH_W:1];
      end

      result.visible = (sx > low) && (sx < X_LIMIT) && (sy > low) && (sy < Y_LIMIT);
      result.item.slot       = '0;
      result.item.screen_x   = sx[SCREEN_W-1:0];
      result.item.screen_y   = sy[SCREEN_W-1:0];
      result.item.x_negative = sx[POS_W-1];
      result.item.size_large = item.cell_large;
      result.item.tile_attr  = (item.cell_attr & ATTR_KEEP)
                             | (ATTR_W'(item.priority_req) << PRIO_LSB);
      result.item.depth      = depth;
   end

endmodule

// ----- rtl/scq_out_reg.sv -----
// Result register stage with valid flag for the rsp_ channel.
// Depends on scq_pkg.
module scq_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  scq_pkg::rsp_item_type load_item,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output scq_pkg::rsp_item_type rsp_item,
   output logic                  free
);
   import scq_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;
   rsp_item_type item_in;

   always_comb begin
      free     = !valid_ff || rsp_tready;
      valid_in = load ? 1'b1 : (valid_ff && !rsp_tready);
      item_in  = load ? load_item : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for sprite_cell_clip_and_queue_core: directed corner cells, then
// random phases under several scroll settings and idle patterns. Depends on scq_pkg.
`timescale 1ns / 1ps

module testbench;
   import scq_pkg::*;

   // Geometry and queue constants, restated here so that an error in the package shows up
   localparam int              QUEUE_SLOTS = 128;
   localparam int              X_END       = 256;
   localparam int              Y_END       = 224;
   localparam int              LOW_SMALL   = -16;
   localparam int              LOW_LARGE   = -32;
   localparam int              DEPTH_ADD   = 16;
   localparam int              DEPTH_TOP   = 127;
   localparam logic [15:0]     ATTR_MASK   = 16'hcfff;
   localparam int              PHASES      = 8;
   localparam int              PHASE_ITEMS = 240;
   localparam int              HOLD_CYCLES = 80;
   localparam int              REQ_BITS    = $bits(req_item_type);
   localparam int              RSP_BITS    = $bits(rsp_item_type);

   typedef struct {
      opcode_type   op;
      req_item_type body;
   } cell_request_t;

   // DUT ports; every input starts at a known value
   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr   = '0;
   logic [POS_W-1:0]        csr_wdata  = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata  = '0;   // object_x .. priority_req, zero pad
   logic                    req_tuser  = 1'b0; // opcode
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;         // slot .. depth, zero pad

   // Stimulus and scoreboard state
   cell_request_t  cells_to_send[$];
   rsp_item_type   expected_sprites[$];
   logic [7:0]     queue_fill      = '0;  // shadow of the core's queue count
   logic [15:0]    scroll_x_shadow = '0;
   logic [15:0]    scroll_y_shadow = '0;
   int             sender_idle_pct = 0;
   int             rsp_stall_pct   = 0;
   int             hold_asks       = 0;
   int             hold_grants     = 0;
   int             hold_left       = 0;
   logic           req_taken       = 1'b0;
   int             bad_results     = 0;

   always #4 clock = ~clock;

   sprite_cell_clip_and_queue_core uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // ---------------------------------------------------------------------------------
   // Predictor: clip one cell against the window and hand out the next queue slot.
   // Everything is 16-bit wrapping math; the 16-bit locals do the wrap for us.
   // ---------------------------------------------------------------------------------
   task automatic place_sprite(input opcode_type op, input req_item_type c);
      logic signed [15:0] depth_sum;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      int                 low;
      int                 half;
      rsp_item_type       e;
      if (op == OP_CLEAR) begin
         queue_fill = '0;
         return;
      end
      if (queue_fill >= QUEUE_SLOTS) return;   // full queue: cell dropped, count held
      depth_sum = c.object_y + DEPTH_ADD - scroll_y_shadow;
      sx        = c.object_x + c.cell_offset_x - scroll_x_shadow;
      sy        = c.object_y + c.cell_offset_y - c.object_z - scroll_y_shadow;
      low       = c.cell_large ? LOW_LARGE : LOW_SMALL;
      // low bound is strict, culled cells leave the count alone
      if (!(sx > low && sx < X_END) || !(sy > low && sy < Y_END)) return;
      if (depth_sum <= 0) begin
         half = 0;
      end else begin
         half = depth_sum / 2;
         if (half > DEPTH_TOP) half = DEPTH_TOP;
      end
      e.slot       = queue_fill[SLOT_W-1:0];
      e.screen_x   = sx[SCREEN_W-1:0];
      e.screen_y   = sy[SCREEN_W-1:0];
      e.x_negative = (sx < 0);
      e.size_large = c.cell_large;
      e.tile_attr  = (c.cell_attr & ATTR_MASK) | (16'(c.priority_req) << PRIO_LSB);
      e.depth      = half[DEPTH_W-1:0];
      expected_sprites.push_back(e);
      queue_fill = queue_fill + 8'd1;
   endtask

   task automatic report_sprite(input string why, input rsp_item_type want,
                                input rsp_item_type got);
      bad_results++;
      if (bad_results <= 10)
         $display("%0t: %s: want slot %0d x %0d y %0d neg %0b big %0b attr %h depth %0d, ",
                  $realtime, why, want.slot, want.screen_x, want.screen_y, want.x_negative,
                  want.size_large, want.tile_attr, want.depth,
                  "got slot %0d x %0d y %0d neg %0b big %0b attr %h depth %0d",
                  got.slot, got.screen_x, got.screen_y, got.x_negative, got.size_large,
                  got.tile_attr, got.depth);
   endtask

   task automatic check_sprite(input rsp_item_type got);
      rsp_item_type want;
      if (expected_sprites.size() == 0) begin
         report_sprite("unexpected sprite entry", '0, got);
         return;
      end
      want = expected_sprites.pop_front();
      if (got.slot !== want.slot || got.screen_x !== want.screen_x ||
          got.screen_y !== want.screen_y || got.x_negative !== want.x_negative ||
          got.size_large !== want.size_large || got.tile_attr !== want.tile_attr ||
          got.depth !== want.depth)
         report_sprite("sprite entry mismatch", want, got);
   endtask

   // ---------------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge. The result check runs before the
   // prediction; with the input and result registers between them they never refer to the same cell.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready)
            check_sprite(rsp_item_type'(rsp_tdata[RSP_BITS-1:0]));
         if (req_tvalid && req_tready)
            place_sprite(opcode_type'(req_tuser), req_item_type'(req_tdata[REQ_BITS-1:0]));
      end
   end

   // ---------------------------------------------------------------------------------
   // Driver: a new transaction is offered only once the previous one was taken.
   // ---------------------------------------------------------------------------------
   always @(negedge clock) begin : cell_driver
      cell_request_t head;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (cells_to_send.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            head = cells_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_TDATA_W'(head.body);
            req_tuser  <= head.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off counted here when one is asked for
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else if (hold_grants != hold_asks) begin
         hold_grants <= hold_asks;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------

   // Target coordinate: mostly inside the window, sometimes right on either edge
   function automatic int pick_coord(input int low, input int high);
      case ($urandom_range(0, 9))
         0:       return int'(low - 1 + int'($urandom_range(0, 2)));
         1:       return int'(high - 2 + int'($urandom_range(0, 3)));
         default: return int'(low + 1 + int'($urandom_range(0, high - low - 2)));
      endcase
   endfunction

   // Cell whose screen position lands on (tx, ty) under the current scroll
   function automatic cell_request_t aim_cell(input int tx, input int ty, input bit big_cell,
                                              input logic [15:0] oy, input logic [15:0] oz,
                                              input logic [15:0] attr, input logic [1:0] prio);
      cell_request_t r;
      r.op                 = OP_CELL;
      r.body.object_x      = 16'($urandom);
      r.body.object_y      = oy;
      r.body.object_z      = oz;
      r.body.cell_offset_x = 16'(tx) - r.body.object_x + scroll_x_shadow;
      r.body.cell_offset_y = 16'(ty) - oy + oz + scroll_y_shadow;
      r.body.cell_large    = big_cell;
      r.body.cell_attr     = attr;
      r.body.priority_req  = prio;
      return r;
   endfunction

   function automatic cell_request_t random_cell(input int clear_pct);
      cell_request_t r;
      logic [127:0]  noise;
      bit            big_cell;
      int            low;
      int            pick;
      logic [15:0]   oy;
      logic [15:0]   oz;
      noise = {$urandom, $urandom, $urandom, $urandom};
      pick  = $urandom_range(0, 99);
      if (pick < clear_pct) begin
         r.op   = OP_CLEAR;
         r.body = noise[REQ_BITS-1:0];
      end else if (pick < clear_pct + 6) begin
         r.op   = OP_CELL;                   // raw noise, nearly always culled
         r.body = noise[REQ_BITS-1:0];
      end else begin
         big_cell = 1'($urandom_range(0, 1));
         low      = big_cell ? LOW_LARGE : LOW_SMALL;
         // half the time keep the object near the scroll so depth is not just 0 or 127
         oy = $urandom_range(0, 1) ? 16'($urandom)
                                   : 16'(scroll_y_shadow + int'($urandom_range(0, 300)) - 40);
         oz = $urandom_range(0, 1) ? 16'($urandom) : 16'(int'($urandom_range(0, 64)) - 32);
         r  = aim_cell(pick_coord(low, X_END), pick_coord(low, Y_END), big_cell, oy, oz,
                       16'($urandom), 2'($urandom_range(0, 3)));
      end
      return r;
   endfunction

   task automatic write_scroll(input csr_reg_type which, input logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= which;
      csr_wdata <= value;
      if (which == REG_SCROLL_X) scroll_x_shadow = value;
      else scroll_y_shadow = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait until every cell is taken and every sprite entry has come back, then let
   // culled cells and clears still in the pipe drain out.
   task automatic drain_core();
      while (cells_to_send.size() != 0 || (req_tvalid && !req_taken) ||
             expected_sprites.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------
   initial begin : main_sequence
      cell_request_t r;
      logic [15:0]   sx_pick;
      logic [15:0]   sy_pick;
      int            clear_pct;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners; scroll is zero after reset
      cells_to_send.push_back(aim_cell(-15, -15, 0, 16'd100, 16'd0, 16'hffff, 2'd0));
      cells_to_send.push_back(aim_cell(-16, 10, 0, 16'd100, 16'd0, 16'h1234, 2'd1));
      cells_to_send.push_back(aim_cell(10, -16, 0, 16'd100, 16'd0, 16'h1234, 2'd2));
      cells_to_send.push_back(aim_cell(255, 223, 0, 16'd100, 16'd0, 16'h0000, 2'd3));
      cells_to_send.push_back(aim_cell(256, 0, 0, 16'd100, 16'd0, 16'h5555, 2'd1));
      cells_to_send.push_back(aim_cell(0, 224, 0, 16'd100, 16'd0, 16'haaaa, 2'd2));
      cells_to_send.push_back(aim_cell(-31, -31, 1, 16'd50, 16'd0, 16'hffff, 2'd3));
      cells_to_send.push_back(aim_cell(-32, 0, 1, 16'd50, 16'd0, 16'h0f0f, 2'd0));
      cells_to_send.push_back(aim_cell(0, -32, 1, 16'd50, 16'd0, 16'hf0f0, 2'd1));
      cells_to_send.push_back(aim_cell(255, 223, 1, 16'd50, 16'd0, 16'h0000, 2'd3));
      // x sum wraps to -2: visible
      r = aim_cell(0, 10, 0, 16'd0, 16'd0, 16'h8001, 2'd2);
      r.body.object_x      = 16'h7fff;
      r.body.cell_offset_x = 16'h7fff;
      cells_to_send.push_back(r);
      // x sum wraps to -32768: culled
      r.body.cell_offset_x = 16'h0001;
      cells_to_send.push_back(r);
      // height at both extremes
      cells_to_send.push_back(aim_cell(5, 5, 0, 16'd0, 16'h8000, 16'h00ff, 2'd1));
      cells_to_send.push_back(aim_cell(5, 5, 1, 16'd0, 16'h7fff, 16'hff00, 2'd2));
      // depth: sum <= 0, odd and even sums, clamp edge, and wrap on a huge object y
      cells_to_send.push_back(aim_cell(20, 20, 0, -16'sd16, 16'd0, 16'h0001, 2'd0));
      cells_to_send.push_back(aim_cell(20, 20, 0, -16'sd15, 16'd0, 16'h0002, 2'd0));
      cells_to_send.push_back(aim_cell(20, 20, 0, -16'sd14, 16'd0, 16'h0003, 2'd0));
      cells_to_send.push_back(aim_cell(20, 20, 0, 16'd238, 16'd0, 16'h0004, 2'd0));
      cells_to_send.push_back(aim_cell(20, 20, 0, 16'd239, 16'd0, 16'h0005, 2'd0));
      cells_to_send.push_back(aim_cell(20, 20, 0, 16'd240, 16'd0, 16'h0006, 2'd0));
      cells_to_send.push_back(aim_cell(20, 20, 0, 16'h7fff, 16'd0, 16'h0007, 2'd0));
      cells_to_send.push_back(aim_cell(20, 20, 0, 16'h8000, 16'd0, 16'h0008, 2'd0));
      // clear with every payload bit set, then a cell that must land in slot 0
      r.op   = OP_CLEAR;
      r.body = '1;
      cells_to_send.push_back(r);
      cells_to_send.push_back(aim_cell(100, 100, 1, 16'd100, 16'd0, 16'h3000, 2'd0));
      drain_core();

      // Random phases: scroll extremes and random values, four idle patterns
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       begin sx_pick = 16'h0000; sy_pick = 16'h0000; end
            1:       begin sx_pick = 16'h8000; sy_pick = 16'h7fff; end
            2:       begin sx_pick = 16'h7fff; sy_pick = 16'h8000; end
            4:       begin sx_pick = 16'h8000; sy_pick = 16'h8000; end
            5:       begin sx_pick = 16'h7fff; sy_pick = 16'h7fff; end
            7:       begin
               sx_pick = 16'(int'($urandom_range(0, 128)) - 64);
               sy_pick = 16'(int'($urandom_range(0, 128)) - 64);
            end
            default: begin sx_pick = 16'($urandom); sy_pick = 16'($urandom); end
         endcase
         write_scroll(REG_SCROLL_X, sx_pick);
         write_scroll(REG_SCROLL_Y, sy_pick);
         @(posedge clock);
         case (phase % 4)
            0:       begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin sender_idle_pct = 46; rsp_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  rsp_stall_pct = 46; end
            default: begin sender_idle_pct = 24; rsp_stall_pct = 24; end
         endcase
         // no clears in two phases so the queue runs full and stays full
         clear_pct = (phase == 2 || phase == 5) ? 0 : 3;
         for (int n = 0; n < PHASE_ITEMS; n++)
            cells_to_send.push_back(random_cell(clear_pct));
         // long receiver hold-off while the sender keeps pushing: the core must backpressure
         if (phase == 0 || phase == 3) hold_asks++;
         drain_core();
      end

      repeat (8) @(negedge clock);
      if (expected_sprites.size() != 0) begin
         bad_results += expected_sprites.size();
         $display("%0d expected sprite entries never arrived", expected_sprites.size());
      end
      if (bad_results == 0) begin
         $display("sprite_cell_clip_and_queue_core regression: pass");
      end else begin
         $display("sprite_cell_clip_and_queue_core regression: fail");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (about 2000 cells with stalls and hold-offs)
   initial begin
      #3200000;
      $display("sprite_cell_clip_and_queue_core regression: fail");
      $finish;
   end

endmodule
